/* rtl/core/bct_pkg.sv */
// shared types and constants for the uf2 block completion tracker
package bct_pkg;

  localparam logic [31:0] RESTART_WORD_A = 32'h20da6d81;
  localparam logic [31:0] RESTART_WORD_B = 32'h747e09d4;
  localparam logic [31:0] UF2_WORD_A     = 32'h0a324655;
  localparam logic [31:0] UF2_WORD_B     = 32'h9e5d5157;
  localparam logic [31:0] UF2_WORD_END   = 32'h0ab16f30;

  localparam int IN_W  = 160;
  localparam int OUT_W = 24;
  localparam int ROW_BITS = 8;

  typedef enum logic [2:0] {
    ACT_NOT_UF2         = 3'd0,
    ACT_RESTART_IGNORED = 3'd1,
    ACT_RESTART_EXIT    = 3'd2,
    ACT_RECORDED        = 3'd3,
    ACT_COMPLETE        = 3'd4
  } act_t;

  // sector classification, computed at the input transfer
  typedef struct packed {
    logic restart;
    logic uf2;
    logic tracked;
    logic in_map;
  } bct_class_t;

endpackage

/* rtl/core/uf2_block_completion_tracker.sv */
// uf2 block completion tracker: sector classification, bitmap marking and completion
// path: the input stage registers the class and the bitmap read, then the update stage
//   writes the output register that drives out_tvalid
// throughput: one sector per cycle while out_tready does not stall the output; the
//   bitmap read-modify-write forwards the row written in the previous cycle
// reset: sync active-low; then a clearing pass zeroes every bitmap row, in_tready held low
module uf2_block_completion_tracker #(
  parameter int MAP_BLOCKS = 8192
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  // magic_first, magic_second, magic_final, block_index, block_total
  input  logic [bct_pkg::IN_W-1:0]  in_tdata,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  // action[2:0], newly_marked[3], marked_count[17:4], zero pad
  output logic [bct_pkg::OUT_W-1:0] out_tdata
);

  localparam int ROWS = (MAP_BLOCKS + 7) / 8;
  localparam int AW   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CW   = $clog2(MAP_BLOCKS + 1);

  // clearing pass
  logic          clr_busy_r;
  logic [AW-1:0] clr_cnt_r;

  // input stage
  logic                s1_vld_r;
  bct_pkg::bct_class_t s1_cls_r;
  logic [AW-1:0]       s1_row_r;
  logic [2:0]          s1_bit_r;
  logic [31:0]         s1_total_r;
  logic                hit_r;
  logic [7:0]          fwd_r;

  // tracker state
  logic          seen_r, seen_nxt;
  logic [CW-1:0] exp_r, exp_nxt;
  logic          poison_r, poison_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  // output register
  logic                     out_vld_r;
  logic [bct_pkg::OUT_W-1:0] out_data_r;

  bct_pkg::bct_class_t in_cls;
  logic [AW-1:0]       in_row;
  logic                in_acc;
  logic                s1_adv;
  logic [7:0]          rd_row;
  logic [7:0]          cur_row;
  logic [7:0]          new_row;
  logic                fresh;
  logic                item_wr;
  logic                ram_wr;
  logic [AW-1:0]       ram_waddr;
  logic [7:0]          ram_wdata;
  bct_pkg::act_t       act;
  logic [31:0]         cnt_ext;

  bct_classify #(
    .MAP_BLOCKS(MAP_BLOCKS)
  ) u_classify (
    .magic_first (in_tdata[31:0]),
    .magic_second(in_tdata[63:32]),
    .magic_final (in_tdata[95:64]),
    .block_index (in_tdata[127:96]),
    .block_total (in_tdata[159:128]),
    .cls         (in_cls)
  );

  assign in_row    = in_tdata[96+AW+2:96+3];
  assign s1_adv    = s1_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !clr_busy_r && (!s1_vld_r || s1_adv);
  assign in_acc    = in_tvalid && in_tready;

  bct_ram #(
    .WIDTH(bct_pkg::ROW_BITS),
    .DEPTH(ROWS)
  ) u_map (
    .clk    (clk),
    .wr_en  (ram_wr),
    .wr_addr(ram_waddr),
    .wr_data(ram_wdata),
    .rd_en  (in_acc),
    .rd_addr(in_row),
    .rd_data(rd_row)
  );

  // update stage
  always_comb begin
    cur_row    = hit_r ? fwd_r : rd_row;
    fresh      = 1'b0;
    new_row    = cur_row;
    seen_nxt   = seen_r;
    exp_nxt    = exp_r;
    poison_nxt = poison_r;
    cnt_nxt    = cnt_r;
    act        = bct_pkg::ACT_NOT_UF2;
    if (s1_cls_r.restart) begin
      act = seen_r ? bct_pkg::ACT_RESTART_EXIT : bct_pkg::ACT_RESTART_IGNORED;
    end else begin
      seen_nxt = 1'b1;
      if (s1_cls_r.uf2) begin
        act = bct_pkg::ACT_RECORDED;
        if (s1_cls_r.tracked) begin
          if (!poison_r && (32'(exp_r) != s1_total_r)) begin
            if ((s1_total_r >= 32'(MAP_BLOCKS)) || (exp_r != '0)) begin
              poison_nxt = 1'b1;
            end else begin
              exp_nxt = CW'(s1_total_r);
            end
          end
          if (s1_cls_r.in_map) begin
            if (!cur_row[s1_bit_r]) begin
              fresh             = 1'b1;
              new_row[s1_bit_r] = 1'b1;
              cnt_nxt           = cnt_r + CW'(1);
            end
            if (!poison_nxt && (exp_nxt != '0) && (cnt_nxt >= exp_nxt)) begin
              act = bct_pkg::ACT_COMPLETE;
            end
          end
        end
      end
    end
  end

  assign item_wr   = s1_adv && fresh;
  assign ram_wr    = clr_busy_r || item_wr;
  assign ram_waddr = clr_busy_r ? clr_cnt_r : s1_row_r;
  assign ram_wdata = clr_busy_r ? 8'h00 : new_row;
  assign cnt_ext   = 32'(cnt_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_cnt_r  <= '0;
      s1_vld_r   <= 1'b0;
      out_vld_r  <= 1'b0;
      seen_r     <= 1'b0;
      exp_r      <= '0;
      poison_r   <= 1'b0;
      cnt_r      <= '0;
    end else begin
      if (clr_busy_r) begin
        clr_cnt_r <= clr_cnt_r + AW'(1);
        if (clr_cnt_r == AW'(ROWS - 1)) begin
          clr_busy_r <= 1'b0;
        end
      end
      if (in_acc) begin
        s1_vld_r <= 1'b1;
      end else if (s1_adv) begin
        s1_vld_r <= 1'b0;
      end
      if (s1_adv) begin
        out_vld_r <= 1'b1;
        seen_r    <= seen_nxt;
        exp_r     <= exp_nxt;
        poison_r  <= poison_nxt;
        cnt_r     <= cnt_nxt;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_cls_r   <= in_cls;
      s1_row_r   <= in_row;
      s1_bit_r   <= in_tdata[98:96];
      s1_total_r <= in_tdata[159:128];
      // the row being written now is not yet visible in the read data
      hit_r      <= item_wr && (s1_row_r == in_row);
      fwd_r      <= new_row;
    end
    if (s1_adv) begin
      out_data_r <= {6'd0, cnt_ext[13:0], fresh, act};
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> !in_tready)
    else $error("input transfer allowed during bitmap clear");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && fresh) |=> (cnt_r == $past(cnt_r) + CW'(1)))
    else $error("distinct count did not step on a new mark");

  a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(s1_adv && fresh) |=> $stable(cnt_r))
    else $error("distinct count changed without a new mark");

  a_fresh_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[3]) |->
      (out_tdata[2:0] == bct_pkg::ACT_RECORDED || out_tdata[2:0] == bct_pkg::ACT_COMPLETE))
    else $error("new mark reported on a sector that is not a tracked block");

endmodule

/* rtl/core/bct_ram.sv */
// generic single-write, single-read ram with registered read data
module bct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic                                   rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

endmodule

/* rtl/core/bct_classify.sv */
// sorts an incoming sector header into restart, uf2, tracked and in-map classes
module bct_classify #(
  parameter int MAP_BLOCKS = 8192
) (
  input  logic [31:0]         magic_first,
  input  logic [31:0]         magic_second,
  input  logic [31:0]         magic_final,
  input  logic [31:0]         block_index,
  input  logic [31:0]         block_total,
  output bct_pkg::bct_class_t cls
);

  always_comb begin
    cls.restart = (magic_first == bct_pkg::RESTART_WORD_A) &&
                  (magic_second == bct_pkg::RESTART_WORD_B);
    cls.uf2     = (magic_first == bct_pkg::UF2_WORD_A) &&
                  (magic_second == bct_pkg::UF2_WORD_B) &&
                  (magic_final == bct_pkg::UF2_WORD_END);
    cls.tracked = (block_total != 32'd0);
    cls.in_map  = (block_index < 32'(MAP_BLOCKS));
  end

endmodule

/* tb/uf2_block_completion_tracker_test.sv */
// self-checking testbench for the uf2 block completion tracker
module uf2_block_completion_tracker_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAP_BLOCKS = 8192;
  localparam int IDLE_LIMIT = 6000;

  // first field in the lowest bits of tdata
  typedef struct packed {
    logic [31:0] block_total;
    logic [31:0] block_index;
    logic [31:0] magic_final;
    logic [31:0] magic_second;
    logic [31:0] magic_first;
  } sector_t;

  typedef struct {
    bct_pkg::act_t action;
    logic          newly_marked;
    logic [13:0]   marked_count;
  } outcome_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_tvalid = 1'b0;
  logic                      in_tready;
  logic [bct_pkg::IN_W-1:0]  in_tdata = '0;
  logic                      out_tvalid;
  logic                      out_tready = 1'b0;
  logic [bct_pkg::OUT_W-1:0] out_tdata;

  sector_t  pending_sectors[$];
  outcome_t awaited_outcomes[$];
  int       fault_count = 0;

  // tracker state mirror
  bit          mark_map [0:MAP_BLOCKS-1];
  bit          wrote_any = 1'b0;
  logic [31:0] latched_total = '0;
  bit          total_bad = 1'b0;
  int unsigned marked = 0;

  uf2_block_completion_tracker #(.MAP_BLOCKS(MAP_BLOCKS)) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic outcome_t sector_outcome(sector_t s);
    outcome_t o;
    o.action = bct_pkg::ACT_RECORDED;
    o.newly_marked = 1'b0;
    if (s.magic_first == bct_pkg::RESTART_WORD_A &&
        s.magic_second == bct_pkg::RESTART_WORD_B) begin
      o.action = wrote_any ? bct_pkg::ACT_RESTART_EXIT : bct_pkg::ACT_RESTART_IGNORED;
    end else begin
      wrote_any = 1'b1;
      if (s.magic_first != bct_pkg::UF2_WORD_A || s.magic_second != bct_pkg::UF2_WORD_B ||
          s.magic_final != bct_pkg::UF2_WORD_END) begin
        o.action = bct_pkg::ACT_NOT_UF2;
      end else if (s.block_total != 32'd0) begin
        if (!total_bad && latched_total != s.block_total) begin
          if (s.block_total >= 32'(MAP_BLOCKS) || latched_total != 32'd0) begin
            total_bad = 1'b1;
          end else begin
            latched_total = s.block_total;
          end
        end
        if (s.block_index < 32'(MAP_BLOCKS)) begin
          if (!mark_map[s.block_index]) begin
            mark_map[s.block_index] = 1'b1;
            marked++;
            o.newly_marked = 1'b1;
          end
          if (!total_bad && latched_total != 32'd0 && marked >= latched_total) begin
            o.action = bct_pkg::ACT_COMPLETE;
          end
        end
      end
    end
    o.marked_count = marked[13:0];
    return o;
  endfunction

  // mostly no gap, some short, a few long, with occasional back-to-back bursts
  function automatic int pick_gap(ref int burst_left);
    int r;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      burst_left = $urandom_range(20, 80);
      return 0;
    end
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic sector_t valid_block(logic [31:0] idx, logic [31:0] total);
    sector_t s;
    s.magic_first  = bct_pkg::UF2_WORD_A;
    s.magic_second = bct_pkg::UF2_WORD_B;
    s.magic_final  = bct_pkg::UF2_WORD_END;
    s.block_index  = idx;
    s.block_total  = total;
    return s;
  endfunction

  function automatic sector_t restart_request(logic [31:0] tail_word);
    sector_t s;
    s.magic_first  = bct_pkg::RESTART_WORD_A;
    s.magic_second = bct_pkg::RESTART_WORD_B;
    s.magic_final  = tail_word;
    s.block_index  = $urandom;
    s.block_total  = $urandom;
    return s;
  endfunction

  // valid block with one bit flipped in one of the magic words
  function automatic sector_t broken_magic(int word, int bit_pos, logic [31:0] total);
    sector_t s;
    s = valid_block($urandom_range(0, MAP_BLOCKS - 1), total);
    case (word)
      0: s.magic_first[bit_pos] = ~s.magic_first[bit_pos];
      1: s.magic_second[bit_pos] = ~s.magic_second[bit_pos];
      default: s.magic_final[bit_pos] = ~s.magic_final[bit_pos];
    endcase
    return s;
  endfunction

  // driver
  int send_gap = 0;
  int send_burst = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        awaited_outcomes.push_back(sector_outcome(sector_t'(in_tdata)));
      end
      if (!in_tvalid || in_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_tvalid <= 1'b0;
        end else if (pending_sectors.size() != 0) begin
          in_tdata <= pending_sectors.pop_front();
          in_tvalid <= 1'b1;
          send_gap = pick_gap(send_burst);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  int stall_left = 0;
  int stall_burst = 0;
  always @(posedge clk) begin
    outcome_t      want;
    bct_pkg::act_t got_action;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got_action = bct_pkg::act_t'(out_tdata[2:0]);
        if (awaited_outcomes.size() == 0) begin
          $display("%0t: unexpected result action %0d newly %0b count %0d", $time,
                   out_tdata[2:0], out_tdata[3], out_tdata[17:4]);
          fault_count++;
        end else begin
          want = awaited_outcomes.pop_front();
          if (got_action != want.action) begin
            $display("%0t: action expected %0d got %0d", $time, want.action, got_action);
            fault_count++;
          end
          if (out_tdata[3] != want.newly_marked) begin
            $display("%0t: newly_marked expected %0b got %0b", $time, want.newly_marked,
                     out_tdata[3]);
            fault_count++;
          end
          if (out_tdata[17:4] != want.marked_count) begin
            $display("%0t: marked_count expected %0d got %0d", $time, want.marked_count,
                     out_tdata[17:4]);
            fault_count++;
          end
        end
        stall_left = pick_gap(stall_burst);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // watchdog on cycles without any transfer; covers the bitmap clearing after reset
  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("uf2_block_completion_tracker test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [31:0] goal;
    logic [31:0] first_total;
    logic [31:0] idx;
    logic [31:0] total;
    sector_t     s;
    int          r;

    goal = $urandom_range(200, 600);
    // sometimes the first tracked total is already too large
    if ($urandom_range(0, 3) == 0) begin
      first_total = $urandom_range(0, 1) ? 32'd8192 : 32'hffffffff;
    end else begin
      first_total = goal;
    end

    // restart before any write, then with writes behind it
    pending_sectors.push_back(restart_request(32'h0));
    pending_sectors.push_back(restart_request(32'hffffffff));
    pending_sectors.push_back(sector_t'('0));
    pending_sectors.push_back(sector_t'({bct_pkg::IN_W{1'b1}}));
    pending_sectors.push_back(restart_request(bct_pkg::UF2_WORD_END));
    pending_sectors.push_back(broken_magic(0, 0, goal));
    pending_sectors.push_back(broken_magic(1, 31, goal));
    pending_sectors.push_back(broken_magic(2, 16, goal));
    s = valid_block(0, goal);
    s.magic_first = bct_pkg::RESTART_WORD_A;
    pending_sectors.push_back(s);
    // untracked block
    pending_sectors.push_back(valid_block(32'd0, 32'd0));
    pending_sectors.push_back(valid_block(32'd0, first_total));
    pending_sectors.push_back(valid_block(32'd0, goal));
    pending_sectors.push_back(valid_block(MAP_BLOCKS - 1, goal));
    // indices past the map
    pending_sectors.push_back(valid_block(MAP_BLOCKS, goal));
    pending_sectors.push_back(valid_block(32'hffffffff, goal));
    pending_sectors.push_back(valid_block(32'd5, 32'd0));
    pending_sectors.push_back(restart_request($urandom));

    for (int i = 0; i < 2000; i++) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        case ($urandom_range(0, 9))
          0:       idx = $urandom_range(0, MAP_BLOCKS - 1);
          1:       idx = 32'(MAP_BLOCKS) + $urandom_range(0, 32'hffffdfff);
          2:       idx = $urandom_range(0, 7);
          default: idx = $urandom_range(0, goal + goal / 4);
        endcase
        total = goal;
        if (r < 7) begin
          total = 32'd0;
        end else if (i >= 1800 && $urandom_range(0, 3) == 0) begin
          // late conflicting or oversized totals poison completion
          case ($urandom_range(0, 4))
            0:       total = MAP_BLOCKS - 1;
            1:       total = MAP_BLOCKS;
            2:       total = 32'hffffffff;
            3:       total = goal + 1;
            default: total = $urandom;
          endcase
        end
        pending_sectors.push_back(valid_block(idx, total));
      end else if (r < 78) begin
        pending_sectors.push_back(broken_magic($urandom_range(0, 2), $urandom_range(0, 31),
                                               goal));
      end else if (r < 88) begin
        s = sector_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
        if (r < 81) s.magic_first = bct_pkg::RESTART_WORD_A;
        pending_sectors.push_back(s);
      end else begin
        pending_sectors.push_back(restart_request($urandom));
      end
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    @(posedge clk);
    #1;
    while (pending_sectors.size() != 0 || in_tvalid || awaited_outcomes.size() != 0) begin
      @(posedge clk);
      #1;
    end
    repeat (8) @(posedge clk);
    if (fault_count == 0) begin
      $display("uf2_block_completion_tracker test passed");
    end else begin
      $display("uf2_block_completion_tracker test failed");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/core/bct_pkg.sv
rtl/core/bct_ram.sv
rtl/core/bct_classify.sv
rtl/core/uf2_block_completion_tracker.sv
tb/uf2_block_completion_tracker_test.sv
